@@ rtl/rfkm_pkg.sv @@
// Shared constants and types for the record filter keyword match block.
package rfkm_pkg;

    localparam int unsigned ID_BYTES   = 4;
    localparam int unsigned KEY_SLOTS  = 16;
    localparam int unsigned KEY_IDX_W  = 4;
    localparam int unsigned KLEN_W     = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    typedef logic [KEY_SLOTS-1:0][7:0] key_bytes_t;
    typedef logic [KEY_IDX_W-1:0]      key_idx_t;
    typedef logic [KLEN_W-1:0]         klen_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USER_ID        = 2'd0,
        REG_KEYWORD_LOW    = 2'd1,
        REG_KEYWORD_HIGH   = 2'd2,
        REG_KEYWORD_LENGTH = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/record_filter_keyword_match_top.sv @@
// Top level of the record filter keyword match block: parser, matcher and result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_ready     | data_byte[7:0]
//  result   | out_valid / out_ready   | record_length, keyword_found
//  config   | cfg_wr_en               | cfg_index[1:0], cfg_data[63:0]
//
// One byte is taken per cycle while in_ready is high; the parser and matcher update
// in the cycle of acceptance and a result appears in the result register on the next cycle.
// The result register is the only stage: in_ready falls only while a result
// is held and out_ready is low. Reset clears the parser state, the configuration registers
// and the result valid flag.
module record_filter_keyword_match_top #(
    parameter int unsigned MAX_KEY_BYTES = 16,
    parameter int unsigned LENGTH_BITS   = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [LENGTH_BITS-1:0]               record_length,
    output logic                                 keyword_found,
    input  logic                                 cfg_wr_en,
    input  logic [rfkm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rfkm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned MC_W = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam rfkm_pkg::klen_t KEY_MAX = rfkm_pkg::KLEN_W'(MAX_KEY_BYTES);

    typedef enum logic [2:0] {
        PH_ID0, PH_ID1, PH_ID2, PH_ID3, PH_SEP, PH_TEXT
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [31:0]                    id_shift_reg, id_shift_next;
    logic [LENGTH_BITS-1:0]         length_count_reg, length_count_next;
    logic [MC_W-1:0]                match_count_reg, match_count_next;
    logic                           found_reg, found_next;
    logic                           stopped_reg, stopped_next;

    logic [31:0]                    user_id_reg;
    logic [63:0]                    keyword_low_reg;
    logic [63:0]                    keyword_high_reg;
    rfkm_pkg::klen_t                keyword_length_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [LENGTH_BITS-1:0]         record_length_reg;
    logic                           keyword_found_reg;

    logic                           in_fire;
    logic                           out_fire;
    logic                           emit;
    logic                           emit_found;
    logic [LENGTH_BITS-1:0]         length_bump;
    rfkm_pkg::key_bytes_t           key_arr;
    rfkm_pkg::klen_t                klen;
    rfkm_pkg::klen_t                mc_ext;
    rfkm_pkg::klen_t                mc_inc;
    logic [7:0]                     key_cur;

    assign in_ready      = !out_valid_reg || out_ready;
    assign in_fire       = in_valid && in_ready;
    assign out_fire      = out_valid_reg && out_ready;
    assign out_valid     = out_valid_reg;
    assign record_length = record_length_reg;
    assign keyword_found = keyword_found_reg;

    assign length_bump = (length_count_reg != LEN_MAX) ?
                         (length_count_reg + LENGTH_BITS'(1)) : LEN_MAX;

    assign key_arr = {keyword_high_reg, keyword_low_reg};
    assign klen    = (keyword_length_reg > KEY_MAX) ? KEY_MAX : keyword_length_reg;
    assign mc_ext  = rfkm_pkg::KLEN_W'(match_count_reg);
    assign mc_inc  = mc_ext + rfkm_pkg::KLEN_W'(1);
    assign key_cur = key_arr[mc_ext[rfkm_pkg::KEY_IDX_W-1:0]];

    // Parser and matcher update for one accepted byte
    always_comb
    begin
        phase_next        = phase_reg;
        id_shift_next     = id_shift_reg;
        length_count_next = length_count_reg;
        match_count_next  = match_count_reg;
        found_next        = found_reg;
        stopped_next      = stopped_reg;
        emit              = 1'b0;
        emit_found        = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_ID1:
                begin
                    id_shift_next[15:8] = data_byte;
                    phase_next          = PH_ID2;
                end
                PH_ID2:
                begin
                    id_shift_next[23:16] = data_byte;
                    phase_next           = PH_ID3;
                end
                PH_ID3:
                begin
                    id_shift_next[31:24] = data_byte;
                    phase_next           = PH_SEP;
                end
                PH_SEP:
                begin
                    phase_next = PH_TEXT;
                end
                PH_TEXT:
                begin
                    length_count_next = length_bump;
                    stopped_next = stopped_reg || (data_byte == rfkm_pkg::ZERO_BYTE);
                    if ((klen != '0) && !found_reg && !stopped_next)
                    begin
                        if ((mc_ext < klen) && (data_byte == key_cur))
                        begin
                            match_count_next = MC_W'(mc_inc);
                        end
                        else if (data_byte == key_arr[0])
                        begin
                            match_count_next = MC_W'(1);
                        end
                        else
                        begin
                            match_count_next = '0;
                        end
                        found_next = (rfkm_pkg::KLEN_W'(match_count_next) >= klen);
                    end
                    if (data_byte == rfkm_pkg::NEWLINE_BYTE)
                    begin
                        emit              = (id_shift_reg == user_id_reg);
                        emit_found        = (klen == '0) || found_next;
                        phase_next        = PH_ID0;
                        id_shift_next     = '0;
                        length_count_next = '0;
                        match_count_next  = '0;
                        found_next        = 1'b0;
                        stopped_next      = 1'b0;
                    end
                end
                default:
                begin
                    id_shift_next[7:0] = data_byte;
                    phase_next         = PH_ID1;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold parser state, configuration and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_ID0;
            id_shift_reg       <= '0;
            length_count_reg   <= '0;
            match_count_reg    <= '0;
            found_reg          <= 1'b0;
            stopped_reg        <= 1'b0;
            user_id_reg        <= '0;
            keyword_low_reg    <= '0;
            keyword_high_reg   <= '0;
            keyword_length_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            id_shift_reg     <= id_shift_next;
            length_count_reg <= length_count_next;
            match_count_reg  <= match_count_next;
            found_reg        <= found_next;
            stopped_reg      <= stopped_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (rfkm_pkg::cfg_reg_t'(cfg_index))
                    rfkm_pkg::REG_USER_ID:
                    begin
                        user_id_reg <= cfg_data[31:0];
                    end
                    rfkm_pkg::REG_KEYWORD_LOW:
                    begin
                        keyword_low_reg <= cfg_data;
                    end
                    rfkm_pkg::REG_KEYWORD_HIGH:
                    begin
                        keyword_high_reg <= cfg_data;
                    end
                    rfkm_pkg::REG_KEYWORD_LENGTH:
                    begin
                        keyword_length_reg <= cfg_data[rfkm_pkg::KLEN_W-1:0];
                    end
                    default:
                    begin
                        keyword_length_reg <= keyword_length_reg;
                    end
                endcase
            end
        end
    end

    // Load the result payload on a reported newline
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            record_length_reg <= length_bump;
            keyword_found_reg <= emit_found;
        end
    end

endmodule

@@ sim/record_filter_keyword_match_checker.sv @@
// Checker for the record filter: tracks the byte and report channels and compares each report.
module record_filter_keyword_match_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [11:0]                     record_length,
    input  logic                            keyword_found,
    input  logic                            cfg_wr_en,
    input  logic [rfkm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfkm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              reports_owed
);

    localparam int unsigned      LEN_W    = 12;
    localparam logic [LEN_W-1:0] LEN_CAP  = '1;
    localparam logic [2:0]       PH_SEP   = 3'd4;
    localparam logic [2:0]       PH_TEXT  = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             found;
    } report_t;

    logic [31:0]            owner_id;
    rfkm_pkg::key_bytes_t   key;
    rfkm_pkg::klen_t        key_len_reg;

    logic [2:0]             phase;
    logic [31:0]            id_gather;
    logic [LEN_W-1:0]       text_len;
    rfkm_pkg::klen_t        hits;
    logic                   found;
    logic                   halted;

    report_t                owed[$];

    task automatic start_record();
        phase     = '0;
        id_gather = '0;
        text_len  = '0;
        hits      = '0;
        found     = 1'b0;
        halted    = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        rfkm_pkg::klen_t span;
        span = (key_len_reg > rfkm_pkg::KEY_SLOTS) ?
               rfkm_pkg::klen_t'(rfkm_pkg::KEY_SLOTS) : key_len_reg;
        if (phase < PH_SEP)
        begin
            id_gather[8*phase +: 8] = b;
            phase++;
        end
        else if (phase == PH_SEP)
        begin
            phase = PH_TEXT;
        end
        else
        begin
            if (text_len != LEN_CAP)
                text_len++;
            if (b == rfkm_pkg::ZERO_BYTE)
                halted = 1'b1;
            if (span != 0 && !found && !halted)
            begin
                if (hits < span && b == key[hits[rfkm_pkg::KEY_IDX_W-1:0]])
                    hits++;
                else if (b == key[0])
                    hits = rfkm_pkg::klen_t'(1);
                else
                    hits = '0;
                if (hits >= span)
                    found = 1'b1;
            end
            if (b == rfkm_pkg::NEWLINE_BYTE)
            begin
                if (id_gather == owner_id)
                    owed.push_back('{text_len, (span == 0) || found});
                start_record();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            owner_id    = '0;
            key         = '0;
            key_len_reg = '0;
            start_record();
            owed.delete();
            mismatches  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed.size() == 0)
                begin
                    $error("unexpected report: record_length %0d keyword_found %0d",
                           record_length, keyword_found);
                    mismatches++;
                end
                else
                begin
                    want = owed.pop_front();
                    if (record_length !== want.length)
                    begin
                        $error("record_length: expected %0d, actual %0d",
                               want.length, record_length);
                        mismatches++;
                    end
                    if (keyword_found !== want.found)
                    begin
                        $error("keyword_found: expected %0d, actual %0d",
                               want.found, keyword_found);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_byte(data_byte);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rfkm_pkg::REG_USER_ID:        owner_id    = cfg_data[31:0];
                    rfkm_pkg::REG_KEYWORD_LOW:    key[7:0]    = cfg_data;
                    rfkm_pkg::REG_KEYWORD_HIGH:   key[15:8]   = cfg_data;
                    rfkm_pkg::REG_KEYWORD_LENGTH:
                        key_len_reg = cfg_data[rfkm_pkg::KLEN_W-1:0];
                    default: ;
                endcase
            end
        end
        reports_owed = owed.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the record filter testbench: clock, reset, record stimulus, report sink and verdict.
module testbench;

    localparam int unsigned GAP_MAX = 18;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [7:0]                      data_byte = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [11:0]                     record_length;
    logic                            keyword_found;
    logic                            cfg_wr_en = 1'b0;
    logic [rfkm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rfkm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int                              mismatches;
    int                              reports_owed;

    bit                              busy = 1'b0;
    logic [31:0]                     owner = '0;
    rfkm_pkg::key_bytes_t            keyword = '0;
    int unsigned                     key_count = 0;
    int unsigned                     bytes_sent = 0;
    logic [7:0]                      line_buf[$];

    record_filter_keyword_match_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_length (record_length),
        .keyword_found (keyword_found),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    record_filter_keyword_match_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_length (record_length),
        .keyword_found (keyword_found),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .reports_owed  (reports_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("record_filter_keyword_match_top: mismatch");
        $finish;
    end

    initial
    begin : report_sink
        int unsigned stall;
        bit          got;
        forever
        begin
            stall = busy ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = out_valid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        bit          taken;
        gap = busy ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    task automatic send_record(input logic [31:0] id, input logic [7:0] sep);
        int i;
        for (i = 0; i < 4; i++)
            send_byte(id[8*i +: 8]);
        send_byte(sep);
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i]);
    endtask

    task automatic load_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic build_text(input int unsigned n, input bit with_zero);
        int unsigned pick;
        int unsigned span;
        int unsigned j;
        logic [7:0]  c;
        line_buf.delete();
        while (line_buf.size() < n)
        begin
            pick = $urandom_range(0, 9);
            if (key_count > 0 && pick < 3)
            begin
                line_buf.push_back(keyword[$urandom_range(0, key_count - 1)]);
            end
            else if (key_count > 0 && pick < 5)
            begin
                span = $urandom_range(1, key_count);
                for (j = 0; j < span; j++)
                    line_buf.push_back(keyword[j]);
            end
            else
            begin
                line_buf.push_back(8'($urandom_range(1, 255)));
            end
        end
        while (line_buf.size() > n)
            void'(line_buf.pop_back());
        for (j = 0; j < n; j++)
        begin
            c = line_buf[j];
            if (c == rfkm_pkg::NEWLINE_BYTE || c == rfkm_pkg::ZERO_BYTE)
                line_buf[j] = 8'h20;
        end
        if (with_zero && n > 0)
            line_buf[$urandom_range(0, n - 1)] = rfkm_pkg::ZERO_BYTE;
        line_buf.push_back(rfkm_pkg::NEWLINE_BYTE);
    endtask

    task automatic wait_idle();
        bit settled;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            settled = (reports_owed == 0);
            @(posedge clk);
        end
        while (!settled);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input rfkm_pkg::cfg_reg_t idx,
                             input logic [rfkm_pkg::CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] uid, input rfkm_pkg::key_bytes_t kw,
                                 input rfkm_pkg::klen_t kl);
        wait_idle();
        write_reg(rfkm_pkg::REG_USER_ID, {32'h0, uid});
        write_reg(rfkm_pkg::REG_KEYWORD_LOW, kw[7:0]);
        write_reg(rfkm_pkg::REG_KEYWORD_HIGH, kw[15:8]);
        write_reg(rfkm_pkg::REG_KEYWORD_LENGTH, rfkm_pkg::CFG_DATA_W'(kl));
        cfg_wr_en <= 1'b0;
        owner     = uid;
        keyword   = kw;
        key_count = (kl > rfkm_pkg::KEY_SLOTS) ? rfkm_pkg::KEY_SLOTS : kl;
    endtask

    initial
    begin : stimulus
        int                   ph;
        int                   i;
        int unsigned          mode;
        int unsigned          kind;
        int unsigned          n;
        int unsigned          goal;
        logic [31:0]          uid;
        logic [31:0]          rid;
        rfkm_pkg::key_bytes_t kw;
        rfkm_pkg::klen_t      kl;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: owner zero, empty keyword
        line_buf.delete();
        line_buf.push_back(rfkm_pkg::NEWLINE_BYTE);
        send_record(32'h0, rfkm_pkg::NEWLINE_BYTE);
        line_buf.delete();
        load_text("x");
        line_buf.push_back(rfkm_pkg::ZERO_BYTE);
        load_text("y\n");
        send_record(32'h0, rfkm_pkg::ZERO_BYTE);
        line_buf.delete();
        line_buf.push_back(rfkm_pkg::NEWLINE_BYTE);
        send_record(32'h0000_0100, 8'h20);

        // keyword ending in newline, restart on repeated first byte
        kw    = '0;
        kw[0] = 8'h61;
        kw[1] = 8'h62;
        kw[2] = rfkm_pkg::NEWLINE_BYTE;
        apply_setting(32'hFFFF_FFFF, kw, rfkm_pkg::klen_t'(3));
        line_buf.delete();
        load_text("aab\n");
        send_record(32'hFFFF_FFFF, 8'hFF);
        line_buf.delete();
        load_text("a");
        line_buf.push_back(rfkm_pkg::ZERO_BYTE);
        load_text("ab\n");
        send_record(32'hFFFF_FFFF, 8'h00);

        // oversized length clamps to a full sixteen-byte keyword
        apply_setting(32'hA5A5_0001, '1, rfkm_pkg::klen_t'(31));
        line_buf.delete();
        for (i = 0; i < 16; i++)
            line_buf.push_back(8'hFF);
        line_buf.push_back(rfkm_pkg::NEWLINE_BYTE);
        send_record(32'hA5A5_0001, 8'h0A);

        // owner changes while a record is half parsed
        line_buf.delete();
        load_text("zz");
        send_record(32'h0BAD_F00D, 8'h3A);
        apply_setting(32'h0BAD_F00D, '1, rfkm_pkg::klen_t'(31));
        line_buf.delete();
        line_buf.push_back(rfkm_pkg::NEWLINE_BYTE);
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i]);

        // saturation of the length count
        kw    = '0;
        kw[0] = 8'h6F;
        kw[1] = 8'h6B;
        apply_setting(32'h1234_5678, kw, rfkm_pkg::klen_t'(2));
        busy = 1'b1;
        build_text(4095, 1'b0);
        send_record(32'h1234_5678, 8'h2C);
        busy = 1'b0;

        for (ph = 0; ph < 8; ph++)
        begin
            mode = $urandom_range(0, 9);
            for (i = 0; i < rfkm_pkg::KEY_SLOTS; i++)
            begin
                if (mode == 0)
                    kw[i] = 8'hFF;
                else if (mode == 1)
                    kw[i] = rfkm_pkg::ZERO_BYTE;
                else if (mode < 4)
                    kw[i] = 8'($urandom_range(0, 255));
                else
                    kw[i] = 8'h61 + 8'($urandom_range(0, 3));
            end
            case (ph)
                0:       uid = 32'h0;
                1:       uid = 32'hFFFF_FFFF;
                default: uid = $urandom;
            endcase
            case (ph)
                0:       kl = rfkm_pkg::klen_t'(0);
                1:       kl = rfkm_pkg::klen_t'(16);
                2:       kl = rfkm_pkg::klen_t'(1);
                3:       kl = rfkm_pkg::klen_t'(31);
                4:       kl = rfkm_pkg::klen_t'(3);
                5:       kl = rfkm_pkg::klen_t'(2);
                6:       kl = rfkm_pkg::klen_t'($urandom_range(0, 31));
                default: kl = rfkm_pkg::klen_t'($urandom_range(4, 8));
            endcase
            apply_setting(uid, kw, kl);
            busy = ($urandom_range(0, 3) == 0);
            goal = bytes_sent + 125;
            while (bytes_sent < goal)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 2)
                begin
                    n = $urandom_range(1, 8);
                    for (i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    kind = $urandom_range(0, 9);
                    if (kind < 7)
                        rid = owner;
                    else if (kind == 7)
                        rid = $urandom;
                    else
                        rid = owner ^ (32'h1 << $urandom_range(0, 31));
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70)
                                                    : $urandom_range(0, 12);
                    build_text(n, $urandom_range(0, 7) == 0);
                    send_record(rid, 8'($urandom_range(0, 255)));
                end
            end
            busy = 1'b0;
        end

        // stream stops part way through a record
        line_buf.delete();
        load_text("abc");
        send_record(owner, 8'h20);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("record_filter_keyword_match_top: match");
        else
            $display("record_filter_keyword_match_top: mismatch");
        $finish;
    end

endmodule

@@ record_filter_keyword_match_top.f @@
rtl/rfkm_pkg.sv
rtl/record_filter_keyword_match_top.sv
sim/record_filter_keyword_match_checker.sv
sim/testbench.sv
